/* hdl/mspfr_pkg.sv */
// Shared types and constants of the MSP v1 frame receiver.
package mspfr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] status_t;

  // Header characters
  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_M      = 8'h4D;
  localparam byte_t CH_LT     = 8'h3C;

  localparam byte_t MAX_PAYLOAD_RESET = 8'd64;

  // Per-byte status codes
  localparam status_t ST_NONE     = 2'd0;
  localparam status_t ST_GOOD     = 2'd1;
  localparam status_t ST_BAD_CSUM = 2'd2;
  localparam status_t ST_SIZE_REJ = 2'd3;

  // Parser view toward the top level
  typedef struct packed {
    logic    hunting;
    status_t frame_status;
  } parser_stat_t;

endpackage

/* hdl/mspfr_if.sv */
// Valid/ready stream interfaces for received bytes and frame status.
interface mspfr_byte_if import mspfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mspfr_status_if import mspfr_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t frame_status;

  modport source (output valid, output frame_status, input ready);
  modport sink (input valid, input frame_status, output ready);
endinterface

/* hdl/mspfr_parser.sv */
// Frame parsing state machine: one state update per received byte.
module mspfr_parser import mspfr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  byte_t        rx_byte,
  input  byte_t        max_payload,
  output parser_stat_t stat
);

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_DOLLAR = 3'd1;
  localparam logic [2:0] PH_M      = 3'd2;
  localparam logic [2:0] PH_ARROW  = 3'd3;
  localparam logic [2:0] PH_SIZE   = 3'd4;
  localparam logic [2:0] PH_BODY   = 3'd5;

  logic [2:0] phase, phase_next;
  byte_t      payload_size, payload_size_next;
  byte_t      payload_count, payload_count_next;
  byte_t      running_xor, running_xor_next;
  status_t    status_next;

  always_comb begin
    phase_next         = phase;
    payload_size_next  = payload_size;
    payload_count_next = payload_count;
    running_xor_next   = running_xor;
    status_next        = ST_NONE;
    case (phase)
      PH_DOLLAR: begin
        phase_next = (rx_byte == CH_M) ? PH_M : PH_HUNT;
      end
      PH_M: begin
        phase_next = (rx_byte == CH_LT) ? PH_ARROW : PH_HUNT;
      end
      PH_ARROW: begin
        if (rx_byte > max_payload) begin
          phase_next  = PH_HUNT;
          status_next = ST_SIZE_REJ;
        end else begin
          payload_size_next = rx_byte;
          running_xor_next  = rx_byte;
          phase_next        = PH_SIZE;
        end
      end
      PH_SIZE: begin
        // command byte
        running_xor_next   = running_xor ^ rx_byte;
        payload_count_next = '0;
        phase_next         = PH_BODY;
      end
      PH_BODY: begin
        if (payload_count < payload_size) begin
          running_xor_next   = running_xor ^ rx_byte;
          payload_count_next = payload_count + 8'd1;
        end else begin
          // checksum byte
          phase_next  = PH_HUNT;
          status_next = (running_xor == rx_byte) ? ST_GOOD : ST_BAD_CSUM;
        end
      end
      default: begin
        // hunting; unused codes fall here too
        phase_next = (rx_byte == CH_DOLLAR) ? PH_DOLLAR : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // Size, count and checksum are always written before they are read.
  always_ff @(posedge clk) begin
    if (step) begin
      payload_size  <= payload_size_next;
      payload_count <= payload_count_next;
      running_xor   <= running_xor_next;
    end
  end

  assign stat.hunting      = (phase == PH_HUNT);
  assign stat.frame_status = status_next;

endmodule

/* hdl/msp_v1_frame_receiver.sv */
// Top level of the MSP v1 request frame receiver.
// Parses '$' 'M' '<' size command payload checksum request frames from a byte
// stream and returns one 2-bit status per received byte: none, frame good,
// checksum bad, or size rejected (size above max_payload). One byte is taken
// per clock while the output register is empty or being drained in the same
// cycle: the parser state updates on each accepted byte and the status lands
// in an output register, valid in the cycle after its byte is accepted.
// max_payload resets to 64; the user writes it through cfg_wr_en/cfg_wr_data
// only while the block is idle, which the block does not enforce. A bad
// header byte drops back to hunting and is not re-examined as a start byte.
module msp_v1_frame_receiver import mspfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_wr_en,
  input  byte_t cfg_wr_data,
  mspfr_byte_if.sink     rx,
  mspfr_status_if.source status
);

  byte_t        max_payload;
  parser_stat_t pstat;
  logic         rx_accept;
  logic         out_valid;
  status_t      out_status;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  // Take a byte when the output register is free or emptying this cycle.
  assign rx.ready  = !out_valid || status.ready;
  assign rx_accept = rx.valid && rx.ready;

  mspfr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (rx_accept),
    .rx_byte     (rx.rx_byte),
    .max_payload (max_payload),
    .stat        (pstat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_accept) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept) begin
      out_status <= pstat.frame_status;
    end
  end

  assign status.valid        = out_valid;
  assign status.frame_status = out_status;

  // Any terminal status sends the parser back to hunting.
  a_end_to_hunt: assert property (@(posedge clk) disable iff (rst)
    rx_accept && (pstat.frame_status != ST_NONE) |=> pstat.hunting)
    else $error("parser not hunting after frame end");

  // Every accepted byte yields a pending status next cycle.
  a_accept_gives_status: assert property (@(posedge clk) disable iff (rst)
    rx_accept |=> status.valid)
    else $error("accepted byte produced no status");

  // An empty output register never stalls the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> rx.ready)
    else $error("input stalled with empty output register");

  // Status comes out only for an accepted byte.
  a_status_source: assert property (@(posedge clk) disable iff (rst)
    !rx_accept && !out_valid |=> !status.valid)
    else $error("status without a received byte");

endmodule
